/* hw/rtl/xbm_pkg.sv */
// ----------------------------------------------------------------------------
// xbm_pkg
// Shared types and constants of the raster bit expander.
// ----------------------------------------------------------------------------
package xbm_pkg;

    localparam int MAX_WIDTH   = 4096;
    localparam int MAX_HEIGHT  = 4096;
    localparam int DIM_W       = 13;
    localparam int ROW_W       = 12;
    localparam int BYTE_W      = 10;
    localparam int CNT_W       = 5;
    localparam int WORD_W      = 16;
    localparam int PIX_W       = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 13;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH  = 3'd0,
        REG_HEIGHT = 3'd1,
        REG_X10    = 3'd2,
        REG_SET    = 3'd3,
        REG_CLEAR  = 3'd4
    } t_xbm_reg;

    typedef struct packed {
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
        logic [BYTE_W-1:0] data_bytes;
        logic              x10;
    } t_xbm_geom;

    typedef struct packed {
        logic [PIX_W-1:0] set_index;
        logic [PIX_W-1:0] clear_index;
    } t_xbm_colour;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [CNT_W-1:0]  count;
        logic              last_img;
    } t_xbm_entry;

    // Map a written size onto 1 .. maxv.
    function automatic logic [DIM_W-1:0] clamp_size(input logic [DIM_W-1:0] v,
                                                    input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > maxv) begin
            r = maxv;
        end
        return r;
    endfunction

endpackage

/* hw/rtl/xbm_cfg_regs.sv */
// ----------------------------------------------------------------------------
// xbm_cfg_regs
// Configuration register file; sizes are stored already clamped.
// ----------------------------------------------------------------------------
module xbm_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [xbm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [xbm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output xbm_pkg::t_xbm_geom               o_geom,
    output xbm_pkg::t_xbm_colour             o_colour,
    output logic                             o_restart
);
    import xbm_pkg::*;

    localparam logic [DIM_W-1:0] MaxW = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] MaxH = DIM_W'(MAX_HEIGHT);

    t_xbm_geom        r_geom;
    t_xbm_colour      r_colour;
    logic [DIM_W-1:0] w_clamped;
    logic [DIM_W:0]   w_round;

    assign w_clamped = clamp_size(i_cfg_data, MaxW);
    assign w_round   = {1'b0, w_clamped} + (DIM_W+1)'(7);

    always_comb begin
        o_restart = 1'b0;
        if (i_cfg_valid) begin
            unique case (t_xbm_reg'(i_cfg_index))
                REG_WIDTH, REG_HEIGHT, REG_X10: o_restart = 1'b1;
                default:                        o_restart = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geom.width       <= DIM_W'(1);
            r_geom.height      <= DIM_W'(1);
            r_geom.data_bytes  <= BYTE_W'(1);
            r_geom.x10         <= 1'b0;
            r_colour.set_index   <= '0;
            r_colour.clear_index <= PIX_W'(1);
        end else if (i_cfg_valid) begin
            unique case (t_xbm_reg'(i_cfg_index))
                REG_WIDTH: begin
                    r_geom.width      <= w_clamped;
                    r_geom.data_bytes <= w_round[BYTE_W+2:3];
                end
                REG_HEIGHT: r_geom.height        <= clamp_size(i_cfg_data, MaxH);
                REG_X10:    r_geom.x10           <= i_cfg_data[0];
                REG_SET:    r_colour.set_index   <= i_cfg_data[PIX_W-1:0];
                REG_CLEAR:  r_colour.clear_index <= i_cfg_data[PIX_W-1:0];
                default: begin
                    // unknown index: drop the write
                end
            endcase
        end
    end

    assign o_geom   = r_geom;
    assign o_colour = r_colour;

endmodule

/* hw/rtl/xbm_front.sv */
// ----------------------------------------------------------------------------
// xbm_front
// Accepts raster words, tracks line position and classifies each word.
// ----------------------------------------------------------------------------
module xbm_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [xbm_pkg::WORD_W-1:0]    i_data_word,
    input  xbm_pkg::t_xbm_geom            i_geom,
    input  logic                          i_restart,
    input  logic                          i_full,
    output logic                          o_push,
    output xbm_pkg::t_xbm_entry           o_entry
);
    import xbm_pkg::*;

    logic [BYTE_W-1:0] r_byte, n_byte;
    logic [ROW_W-1:0]  r_row, n_row;
    logic              w_two;
    logic [DIM_W-1:0]  w_rem;
    logic [BYTE_W:0]   w_next_byte;
    logic [ROW_W:0]    w_next_row;
    logic              w_end_line;
    logic              w_end_img;
    logic [CNT_W-1:0]  w_count;

    assign o_in_ready = !i_full;
    assign o_push     = i_in_valid && !i_full;

    assign w_two       = i_geom.x10 &&
                         (({1'b0, r_byte} + (BYTE_W+1)'(1)) < {1'b0, i_geom.data_bytes});
    assign w_rem       = i_geom.width - {r_byte, 3'b000};
    assign w_next_byte = {1'b0, r_byte} + (w_two ? (BYTE_W+1)'(2) : (BYTE_W+1)'(1));
    assign w_end_line  = w_next_byte >= {1'b0, i_geom.data_bytes};
    assign w_next_row  = {1'b0, r_row} + (ROW_W+1)'(1);
    assign w_end_img   = w_end_line && (w_next_row >= i_geom.height);

    always_comb begin
        if (w_two) begin
            w_count = (w_rem >= DIM_W'(16)) ? CNT_W'(16) : w_rem[CNT_W-1:0];
        end else begin
            w_count = (w_rem >= DIM_W'(8)) ? CNT_W'(8) : w_rem[CNT_W-1:0];
        end
    end

    always_comb begin
        n_byte = r_byte;
        n_row  = r_row;
        if (w_end_line) begin
            n_byte = '0;
            n_row  = w_end_img ? '0 : w_next_row[ROW_W-1:0];
        end else begin
            n_byte = w_next_byte[BYTE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_byte <= '0;
            r_row  <= '0;
        end else if (o_push) begin
            r_byte <= n_byte;
            r_row  <= n_row;
        end
    end

    assign o_entry.word     = i_data_word;
    assign o_entry.count    = w_count;
    assign o_entry.last_img = w_end_img;

endmodule

/* hw/rtl/xbm_queue.sv */
// ----------------------------------------------------------------------------
// xbm_queue
// Short FIFO of classified words between front and back.
// ----------------------------------------------------------------------------
module xbm_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  xbm_pkg::t_xbm_entry  i_entry,
    output logic                 o_full,
    output logic                 o_valid,
    output xbm_pkg::t_xbm_entry  o_entry,
    input  logic                 i_pop
);
    import xbm_pkg::*;

    t_xbm_entry          r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_level;
    logic                w_pop;

    assign o_full  = r_level == (QUEUE_AW+1)'(QUEUE_DEPTH);
    assign o_valid = r_level != '0;
    assign o_entry = r_mem[r_rd_ptr];
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
            if (i_push && !w_pop) begin
                r_level <= r_level + (QUEUE_AW+1)'(1);
            end else if (w_pop && !i_push) begin
                r_level <= r_level - (QUEUE_AW+1)'(1);
            end
        end
    end

endmodule

/* hw/rtl/xbm_back.sv */
// ----------------------------------------------------------------------------
// xbm_back
// Expands one queued word into pixel results, one per cycle while the output accepts.
// ----------------------------------------------------------------------------
module xbm_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  xbm_pkg::t_xbm_entry           i_entry,
    output logic                          o_pop,
    input  xbm_pkg::t_xbm_colour          i_colour,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [xbm_pkg::PIX_W-1:0]     o_pixel_index,
    output logic                          o_last_of_word,
    output logic                          o_last_of_image
);
    import xbm_pkg::*;

    localparam int POS_W = $clog2(WORD_W);

    logic              r_busy;
    logic [WORD_W-1:0] r_word;
    logic [CNT_W-1:0]  r_remain;
    logic [POS_W-1:0]  r_pos;
    logic              r_last_img;
    logic              r_out_valid;
    logic [PIX_W-1:0]  r_pix;
    logic              r_low;
    logic              r_loi;
    logic              w_out_free;
    logic              w_emit;
    logic              w_final;
    logic              w_load;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_emit     = r_busy && w_out_free;
    assign w_final    = w_emit && (r_remain == CNT_W'(1));
    assign w_load     = i_valid && (!r_busy || w_final);
    assign o_pop      = w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_busy <= 1'b1;
            end else if (w_final) begin
                r_busy <= 1'b0;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_word     <= i_entry.word;
            r_remain   <= i_entry.count;
            r_pos      <= '0;
            r_last_img <= i_entry.last_img;
        end else if (w_emit) begin
            r_remain <= r_remain - CNT_W'(1);
            r_pos    <= r_pos + POS_W'(1);
        end
        if (w_emit) begin
            r_pix <= r_word[r_pos] ? i_colour.set_index : i_colour.clear_index;
            r_low <= r_remain == CNT_W'(1);
            r_loi <= (r_remain == CNT_W'(1)) && r_last_img;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_pixel_index   = r_pix;
    assign o_last_of_word  = r_low;
    assign o_last_of_image = r_loi;

endmodule

/* hw/rtl/xbm_raster_bit_expander.sv */
// ----------------------------------------------------------------------------
// xbm_raster_bit_expander
// Expands XBM raster words (X10 or X11) into 8-bit pixel indices, LSB first.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+--------------------------
//  in       | sink      | i_in_valid / o_in_ready    | i_data_word[15:0]
//  out      | source    | o_out_valid / i_out_ready  | o_pixel_index[7:0],
//           |           |                            | o_last_of_word,
//           |           |                            | o_last_of_image
//  cfg      | sink      | i_cfg_valid / o_cfg_ready  | i_cfg_index[2:0],
//           |           |                            | i_cfg_data[12:0]
//
//  A word is classified in the front on acceptance and yields 1 to 16 pixels
//  in the back, one per cycle while the output accepts (up to 8 per X11 byte,
//  up to 16 per X10 word); the back's serial emitter sets the sustained rate.
//  The front keeps accepting while the four-entry queue has room, so a stalled
//  output fills the queue before o_in_ready drops.
//  Each result passes the queue, the back's word register and output register.
//  Reset is synchronous: position, queue and output valid clear; the config
//  registers return to width 1, height 1, X11, set index 0, clear index 1.
//  Configuration requests are always taken; a geometry write restarts the
//  image position.
//
module xbm_raster_bit_expander (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [xbm_pkg::WORD_W-1:0]       i_data_word,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [xbm_pkg::PIX_W-1:0]        o_pixel_index,
    output logic                             o_last_of_word,
    output logic                             o_last_of_image,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [xbm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [xbm_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import xbm_pkg::*;

    t_xbm_geom   geom;
    t_xbm_colour colour;
    logic        restart;
    logic        q_full;
    logic        q_push;
    logic        q_valid;
    logic        q_pop;
    t_xbm_entry  push_entry;
    t_xbm_entry  head_entry;

    // The register file never stalls a request.
    assign o_cfg_ready = 1'b1;

    xbm_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_geom      (geom),
        .o_colour    (colour),
        .o_restart   (restart)
    );

    // Classify each word: pixel count after clipping, end of image.
    xbm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_data_word (i_data_word),
        .i_geom      (geom),
        .i_restart   (restart),
        .i_full      (q_full),
        .o_push      (q_push),
        .o_entry     (push_entry)
    );

    // Decouple word acceptance from the pixel-rate back end.
    xbm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (push_entry),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_entry (head_entry),
        .i_pop   (q_pop)
    );

    // Emit one pixel per cycle; hold the output register under back-pressure.
    xbm_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (q_valid),
        .i_entry         (head_entry),
        .o_pop           (q_pop),
        .i_colour        (colour),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_pixel_index   (o_pixel_index),
        .o_last_of_word  (o_last_of_word),
        .o_last_of_image (o_last_of_image)
    );

    // End of image only ever falls on the last pixel of a word.
    a_loi_implies_low : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_last_of_image || o_last_of_word))
        else $error("last_of_image without last_of_word");

    // The back end pops only a queue entry that exists.
    a_pop_valid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    // No word enters while the queue is full.
    a_push_room : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !q_push)
        else $error("queue pushed while full");

    // Nothing leaves in the cycle after reset.
    a_reset_quiet : assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("output valid straight after reset");

endmodule
